// ===== design/gap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gap_pkg;

   // output angle field, 1/1024 degree
   localparam int ANGLE_BITS = 21;
   // internal angles in 1/65536 degree
   localparam int ANG_W = 27;
   localparam int Z_W = 25;
   localparam int GUARD_SHIFT = 24;
   localparam int FLAT_W = 20;

   localparam logic [FLAT_W-1:0] FLAT_SCALE = FLAT_W'(1000000);
   localparam logic signed [Z_W-1:0] Z_ONE = Z_W'(1);
   localparam logic signed [Z_W-1:0] Z_DEG_90_M1 = Z_W'(90 * 65536 - 1);
   localparam logic signed [ANG_W-1:0] DEG_90 = ANG_W'(90 * 65536);
   localparam logic signed [ANG_W-1:0] DEG_180 = ANG_W'(180 * 65536);
   localparam logic signed [ANG_W-1:0] DEG_360 = ANG_W'(360 * 65536);

   typedef enum logic [1:0] {
      QUAD_1 = 2'd0,
      QUAD_2 = 2'd1,
      QUAD_3 = 2'd2,
      QUAD_4 = 2'd3
   } quad_type;

   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic x_zero;
      logic y_zero;
   } angle_tag_type;

   // atan(2^-i) in 1/65536 degree, rounded to nearest
   function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         0: v = Z_W'(2949120);
         1: v = Z_W'(1740967);
         2: v = Z_W'(919879);
         3: v = Z_W'(466945);
         4: v = Z_W'(234379);
         5: v = Z_W'(117304);
         6: v = Z_W'(58666);
         7: v = Z_W'(29335);
         8: v = Z_W'(14668);
         9: v = Z_W'(7334);
         10: v = Z_W'(3667);
         11: v = Z_W'(1833);
         12: v = Z_W'(917);
         13: v = Z_W'(458);
         14: v = Z_W'(229);
         15: v = Z_W'(115);
         16: v = Z_W'(57);
         17: v = Z_W'(29);
         18: v = Z_W'(14);
         19: v = Z_W'(7);
         20: v = Z_W'(4);
         21: v = Z_W'(2);
         22: v = Z_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== design/gap_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gap_req_if #(parameter int COORD_BITS = 28);
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] stop_x;
   logic signed [COORD_BITS-1:0] stop_y;
   logic signed [COORD_BITS-1:0] offset_i;
   logic signed [COORD_BITS-1:0] offset_j;
   logic clockwise;
   logic multi_quadrant;

   modport source(output valid, start_x, start_y, stop_x, stop_y, offset_i, offset_j,
                  clockwise, multi_quadrant, input ready);
   modport sink(input valid, start_x, start_y, stop_x, stop_y, offset_i, offset_j,
                clockwise, multi_quadrant, output ready);
endinterface

interface gap_rsp_if #(parameter int COORD_BITS = 28);
   logic valid;
   logic ready;
   logic signed [COORD_BITS:0] center_x;
   logic signed [COORD_BITS:0] center_y;
   logic [COORD_BITS+2:0] box_width;
   logic [COORD_BITS+2:0] box_height;
   logic signed [gap_pkg::ANGLE_BITS-1:0] start_angle;
   logic signed [gap_pkg::ANGLE_BITS-1:0] end_angle;

   modport source(output valid, center_x, center_y, box_width, box_height,
                  start_angle, end_angle, input ready);
   modport sink(input valid, center_x, center_y, box_width, box_height,
                start_angle, end_angle, output ready);
endinterface

`default_nettype wire

// ===== design/gap_delay.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gap_delay #(
   parameter int W = 8,
   parameter int DEPTH = 1
) (
   input  wire logic         clock,
   input  wire logic         en,
   input  wire logic [W-1:0] d,
   output logic      [W-1:0] q
);

   generate
      if (DEPTH == 0) begin : g_none
         assign q = d;
      end else begin : g_line
         logic [W-1:0] tap_ff [0:DEPTH-1];
         always_ff @(posedge clock) begin
            if (en) begin
               tap_ff[0] <= d;
               for (int k = 1; k < DEPTH; k++) begin
                  tap_ff[k] <= tap_ff[k-1];
               end
            end
         end
         assign q = tap_ff[DEPTH-1];
      end
   endgenerate

endmodule

`default_nettype wire

// ===== design/gap_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gap_cordic_cell #(
   parameter int STAGE = 0,
   parameter int XW = 56
) (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic signed [XW-1:0]           x_up,
   input  wire logic signed [XW-1:0]           y_up,
   input  wire logic signed [gap_pkg::Z_W-1:0] z_up,
   input  wire gap_pkg::angle_tag_type         tag_up,
   output logic signed [XW-1:0]                x_dn,
   output logic signed [XW-1:0]                y_dn,
   output logic signed [gap_pkg::Z_W-1:0]      z_dn,
   output gap_pkg::angle_tag_type              tag_dn
);

   localparam logic signed [gap_pkg::Z_W-1:0] ATAN = gap_pkg::atan_q16(STAGE);

   logic signed [XW-1:0] xs, ys;
   logic signed [XW-1:0] x_in, y_in, x_ff, y_ff;
   logic signed [gap_pkg::Z_W-1:0] z_in, z_ff;
   gap_pkg::angle_tag_type tag_ff;

   always_comb begin
      xs = x_up >>> STAGE;
      ys = y_up >>> STAGE;
      if (!y_up[XW-1]) begin
         x_in = x_up + ys;
         y_in = y_up - xs;
         z_in = z_up + ATAN;
      end else begin
         x_in = x_up - ys;
         y_in = y_up + xs;
         z_in = z_up - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
         tag_ff <= tag_up;
      end
   end

   assign x_dn = x_ff;
   assign y_dn = y_ff;
   assign z_dn = z_ff;
   assign tag_dn = tag_ff;

endmodule

`default_nettype wire

// ===== design/gap_angle.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gap_angle #(
   parameter int STAGES = 24,
   parameter int V_W = 30
) (
   input  wire logic                             clock,
   input  wire logic                             en,
   input  wire logic signed [V_W-1:0]            vx,
   input  wire logic signed [V_W-1:0]            vy,
   output logic signed [gap_pkg::ANG_W-1:0]      angle
);

   localparam int XW = V_W + gap_pkg::GUARD_SHIFT + 2;
   localparam int ZW = gap_pkg::Z_W;
   localparam int AW = gap_pkg::ANG_W;

   logic [V_W-1:0] mag_x, mag_y;
   logic signed [XW-1:0] x0_in, y0_in;
   gap_pkg::angle_tag_type tag0_in;

   logic signed [XW-1:0] cx [0:STAGES];
   logic signed [XW-1:0] cy [0:STAGES];
   logic signed [ZW-1:0] cz [0:STAGES];
   gap_pkg::angle_tag_type ct [0:STAGES];

   logic signed [XW-1:0] x0_ff, y0_ff;
   gap_pkg::angle_tag_type tag0_ff;

   logic signed [ZW-1:0] z_cl;
   logic signed [AW-1:0] t, angle_in, angle_ff;
   gap_pkg::angle_tag_type tg;

   always_comb begin
      mag_x = vx[V_W-1] ? V_W'(-vx) : V_W'(vx);
      mag_y = vy[V_W-1] ? V_W'(-vy) : V_W'(vy);
      x0_in = $signed({{(XW-V_W){1'b0}}, mag_x} << gap_pkg::GUARD_SHIFT);
      y0_in = $signed({{(XW-V_W){1'b0}}, mag_y} << gap_pkg::GUARD_SHIFT);
      tag0_in.x_neg = vx[V_W-1];
      tag0_in.y_neg = vy[V_W-1];
      tag0_in.x_zero = (vx == '0);
      tag0_in.y_zero = (vy == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
         tag0_ff <= tag0_in;
      end
   end

   assign cx[0] = x0_ff;
   assign cy[0] = y0_ff;
   assign cz[0] = '0;
   assign ct[0] = tag0_ff;

   generate
      for (genvar i = 0; i < STAGES; i++) begin : g_cell
         gap_cordic_cell #(.STAGE(i), .XW(XW)) u_cell (
            .clock  (clock),
            .en     (en),
            .x_up   (cx[i]),
            .y_up   (cy[i]),
            .z_up   (cz[i]),
            .tag_up (ct[i]),
            .x_dn   (cx[i+1]),
            .y_dn   (cy[i+1]),
            .z_dn   (cz[i+1]),
            .tag_dn (ct[i+1])
         );
      end
   endgenerate

   // clamp to the open first quadrant, then fold into the vector's quadrant
   always_comb begin
      tg = ct[STAGES];
      if (cz[STAGES] < gap_pkg::Z_ONE) begin
         z_cl = gap_pkg::Z_ONE;
      end else if (cz[STAGES] > gap_pkg::Z_DEG_90_M1) begin
         z_cl = gap_pkg::Z_DEG_90_M1;
      end else begin
         z_cl = cz[STAGES];
      end
      t = {{(AW-ZW){z_cl[ZW-1]}}, z_cl};
      if (tg.y_zero) begin
         angle_in = tg.x_neg ? gap_pkg::DEG_180 : '0;
      end else if (tg.x_zero) begin
         angle_in = tg.y_neg ? -gap_pkg::DEG_90 : gap_pkg::DEG_90;
      end else if (!tg.x_neg) begin
         angle_in = tg.y_neg ? -t : t;
      end else begin
         angle_in = tg.y_neg ? t - gap_pkg::DEG_180 : gap_pkg::DEG_180 - t;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign angle = angle_ff;

endmodule

`default_nettype wire

// ===== design/gap_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gap_sqrt_cell #(
   parameter int BIT = 0,
   parameter int R_W = 30,
   parameter int S_W = 60
) (
   input  wire logic           clock,
   input  wire logic           en,
   input  wire logic [S_W-1:0] rem_up,
   input  wire logic [R_W-1:0] root_up,
   input  wire logic           flat_up,
   output logic      [S_W-1:0] rem_dn,
   output logic      [R_W-1:0] root_dn,
   output logic                flat_dn
);

   logic [S_W-1:0] trial, rem_in, rem_ff;
   logic [R_W-1:0] root_in, root_ff;
   logic flat_ff;

   // (r + 2^b)^2 <= s  <=>  s - r^2 >= r*2^(b+1) + 2^(2b)
   always_comb begin
      trial = ({{(S_W-R_W){1'b0}}, root_up} << (BIT + 1)) | (S_W'(1) << (2 * BIT));
      if (rem_up >= trial) begin
         rem_in = rem_up - trial;
         root_in = root_up | (R_W'(1) << BIT);
      end else begin
         rem_in = rem_up;
         root_in = root_up;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         root_ff <= root_in;
         flat_ff <= flat_up;
      end
   end

   assign rem_dn = rem_ff;
   assign root_dn = root_ff;
   assign flat_dn = flat_ff;

endmodule

`default_nettype wire

// ===== design/gap_diam.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gap_diam #(
   parameter int V_W = 30
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic signed [V_W-1:0] vx,
   input  wire logic signed [V_W-1:0] vy,
   output logic [V_W:0]              box,
   output logic                      flat
);

   localparam int M_W = V_W - 1;
   localparam int R_W = V_W;
   localparam int S_W = 2 * R_W;
   localparam int FW = gap_pkg::FLAT_W;

   logic [V_W-1:0] full_x, full_y;
   logic [M_W-1:0] ax_ff, ay_ff, axd_ff;
   logic [2*M_W-1:0] sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [M_W+FW-1:0] ym_in, ym_ff;
   logic [S_W-1:0] sum_ff;
   logic flat0_ff;

   logic [S_W-1:0] rc [0:R_W];
   logic [R_W-1:0] qc [0:R_W];
   logic fc [0:R_W];

   logic [S_W+3:0] rem16, lim_hi, lim_lo;
   logic [R_W+1:0] d;
   logic [R_W:0] box_in, box_ff;
   logic flat_ff;

   always_comb begin
      full_x = vx[V_W-1] ? V_W'(-vx) : V_W'(vx);
      full_y = vy[V_W-1] ? V_W'(-vy) : V_W'(vy);
      sqx_in = ax_ff * ax_ff;
      sqy_in = ay_ff * ay_ff;
      ym_in = ay_ff * gap_pkg::FLAT_SCALE;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax_ff <= full_x[M_W-1:0];
         ay_ff <= full_y[M_W-1:0];
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         ym_ff <= ym_in;
         axd_ff <= ax_ff;
         sum_ff <= S_W'(sqx_ff) + S_W'(sqy_ff);
         flat0_ff <= (ym_ff <= {{FW{1'b0}}, axd_ff});
      end
   end

   assign rc[0] = sum_ff;
   assign qc[0] = '0;
   assign fc[0] = flat0_ff;

   generate
      for (genvar k = 0; k < R_W; k++) begin : g_cell
         gap_sqrt_cell #(.BIT(R_W - 1 - k), .R_W(R_W), .S_W(S_W)) u_cell (
            .clock   (clock),
            .en      (en),
            .rem_up  (rc[k]),
            .root_up (qc[k]),
            .flat_up (fc[k]),
            .rem_dn  (rc[k+1]),
            .root_dn (qc[k+1]),
            .flat_dn (fc[k+1])
         );
      end
   endgenerate

   // round 2*sqrt to nearest from root and remainder
   always_comb begin
      rem16 = {rc[R_W], 4'b0000};
      lim_hi = {{(S_W-R_W){1'b0}}, qc[R_W], 4'b0000}
             + {{(S_W-R_W+1){1'b0}}, qc[R_W], 3'b000} + (S_W+4)'(9);
      lim_lo = {{(S_W-R_W+1){1'b0}}, qc[R_W], 3'b000} + (S_W+4)'(1);
      d = {1'b0, qc[R_W], 1'b0};
      if (rem16 >= lim_hi) begin
         d = d + (R_W+2)'(2);
      end else if (rem16 >= lim_lo) begin
         d = d + (R_W+2)'(1);
      end
      box_in = d[R_W+1] ? '1 : d[R_W:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         box_ff <= box_in;
         flat_ff <= fc[R_W];
      end
   end

   assign box = box_ff;
   assign flat = flat_ff;

endmodule

`default_nettype wire

// ===== design/gerber_arc_parameters_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Circular arc parameters: one arc segment per req transfer, one result per rsp transfer,
// in order. A new segment is taken every cycle while the result side keeps up; a stall at
// rsp holds the whole pipeline. The path runs through two front stages (quadrant and
// centre, then radius vectors), the longer of the CORDIC cell chain and the bit-per-cell
// square root chain, and the output register.

module gerber_arc_parameters_top #(
   parameter int CORDIC_STAGES = 24,
   parameter int COORD_BITS = 28
) (
   input wire logic  clock,
   input wire logic  reset,
   gap_req_if.sink   req_ch,
   gap_rsp_if.source rsp_ch
);

   localparam int C = COORD_BITS;
   localparam int V_W = C + 2;
   localparam int AW = gap_pkg::ANG_W;
   localparam int LA = CORDIC_STAGES + 2;
   localparam int LD = V_W + 4;
   localparam int L = (LA > LD) ? LA : LD;
   localparam int P = L + 2;

   typedef struct packed {
      logic signed [C:0] cx;
      logic signed [C:0] cy;
      logic cw;
      logic mq;
      gap_pkg::quad_type q;
   } side_type;

   logic advance, req_ready, req_fire;
   logic [P-1:0] vld_ff, vld_in;

   // front stage a
   gap_pkg::quad_type q_raw, q_sel;
   logic sub_x, sub_y;
   logic signed [C:0] cx_in, cy_in;
   logic signed [C:0] a_cx_ff, a_cy_ff;
   logic signed [C-1:0] a_sx_ff, a_sy_ff, a_ex_ff, a_ey_ff;
   logic a_cw_ff, a_mq_ff;
   gap_pkg::quad_type a_q_ff;

   // front stage b
   logic signed [V_W-1:0] v1x, v1y, v2x, v2y;
   logic signed [V_W-1:0] b_v1x_ff, b_v1y_ff, b_v2x_ff, b_v2y_ff;
   side_type b_side_ff, side_in, side_d;

   logic signed [AW-1:0] al_u, be_u, al, be;
   logic [C+2:0] d1_u, d2_u, d1, d2;
   logic f1_u, f2_u, f1, f2;

   logic signed [AW-1:0] a1, a2, r1, r2;
   logic [C+2:0] bw, bh;
   logic signed [C:0] rsp_cx_ff, rsp_cy_ff;
   logic [C+2:0] rsp_bw_ff, rsp_bh_ff;
   logic signed [gap_pkg::ANGLE_BITS-1:0] rsp_a1_ff, rsp_a2_ff;
   logic rsp_valid_ff, rsp_valid_in;

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign req_ready = advance && !reset;
   assign req_fire = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;

   always_comb begin
      if (req_ch.start_x > req_ch.stop_x) begin
         q_raw = (req_ch.start_y < req_ch.stop_y) ? gap_pkg::QUAD_1 : gap_pkg::QUAD_2;
      end else begin
         q_raw = (req_ch.start_y > req_ch.stop_y) ? gap_pkg::QUAD_3 : gap_pkg::QUAD_4;
      end
      // clockwise arcs rotate the quadrant by two
      if (req_ch.clockwise) begin
         case (q_raw)
            gap_pkg::QUAD_1: q_sel = gap_pkg::QUAD_3;
            gap_pkg::QUAD_2: q_sel = gap_pkg::QUAD_4;
            gap_pkg::QUAD_3: q_sel = gap_pkg::QUAD_1;
            default:         q_sel = gap_pkg::QUAD_2;
         endcase
      end else begin
         q_sel = q_raw;
      end
      sub_x = !req_ch.multi_quadrant && (q_sel == gap_pkg::QUAD_1 || q_sel == gap_pkg::QUAD_4);
      sub_y = !req_ch.multi_quadrant && (q_sel == gap_pkg::QUAD_1 || q_sel == gap_pkg::QUAD_2);
      cx_in = sub_x ? (C+1)'(req_ch.start_x) - (C+1)'(req_ch.offset_i)
                    : (C+1)'(req_ch.start_x) + (C+1)'(req_ch.offset_i);
      cy_in = sub_y ? (C+1)'(req_ch.start_y) - (C+1)'(req_ch.offset_j)
                    : (C+1)'(req_ch.start_y) + (C+1)'(req_ch.offset_j);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_cx_ff <= cx_in;
         a_cy_ff <= cy_in;
         a_sx_ff <= req_ch.start_x;
         a_sy_ff <= req_ch.start_y;
         a_ex_ff <= req_ch.stop_x;
         a_ey_ff <= req_ch.stop_y;
         a_cw_ff <= req_ch.clockwise;
         a_mq_ff <= req_ch.multi_quadrant;
         a_q_ff <= q_sel;
      end
   end

   // radius vectors, folded to magnitudes in single-quadrant mode
   always_comb begin
      v1x = V_W'(a_sx_ff) - V_W'(a_cx_ff);
      v1y = V_W'(a_sy_ff) - V_W'(a_cy_ff);
      v2x = V_W'(a_ex_ff) - V_W'(a_cx_ff);
      v2y = V_W'(a_ey_ff) - V_W'(a_cy_ff);
      if (!a_mq_ff) begin
         if (v1x[V_W-1]) v1x = -v1x;
         if (v1y[V_W-1]) v1y = -v1y;
         if (v2x[V_W-1]) v2x = -v2x;
         if (v2y[V_W-1]) v2y = -v2y;
      end
      side_in.cx = a_cx_ff;
      side_in.cy = a_cy_ff;
      side_in.cw = a_cw_ff;
      side_in.mq = a_mq_ff;
      side_in.q = a_q_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_v1x_ff <= v1x;
         b_v1y_ff <= v1y;
         b_v2x_ff <= v2x;
         b_v2y_ff <= v2y;
         b_side_ff <= side_in;
      end
   end

   gap_angle #(.STAGES(CORDIC_STAGES), .V_W(V_W)) u_angle_1 (
      .clock (clock), .en (advance), .vx (b_v1x_ff), .vy (b_v1y_ff), .angle (al_u)
   );

   gap_angle #(.STAGES(CORDIC_STAGES), .V_W(V_W)) u_angle_2 (
      .clock (clock), .en (advance), .vx (b_v2x_ff), .vy (b_v2y_ff), .angle (be_u)
   );

   gap_diam #(.V_W(V_W)) u_diam_1 (
      .clock (clock), .en (advance), .vx (b_v1x_ff), .vy (b_v1y_ff),
      .box (d1_u), .flat (f1_u)
   );

   gap_diam #(.V_W(V_W)) u_diam_2 (
      .clock (clock), .en (advance), .vx (b_v2x_ff), .vy (b_v2y_ff),
      .box (d2_u), .flat (f2_u)
   );

   gap_delay #(.W(2 * AW), .DEPTH(L - LA)) u_dly_angle (
      .clock (clock), .en (advance), .d ({al_u, be_u}), .q ({al, be})
   );

   gap_delay #(.W(2 * (C + 4)), .DEPTH(L - LD)) u_dly_diam (
      .clock (clock), .en (advance), .d ({d1_u, f1_u, d2_u, f2_u}), .q ({d1, f1, d2, f2})
   );

   gap_delay #(.W($bits(side_type)), .DEPTH(L)) u_dly_side (
      .clock (clock), .en (advance), .d (b_side_ff), .q (side_d)
   );

   always_comb begin
      if (side_d.mq) begin
         a1 = al;
         a2 = be;
         if (a1 < 0) begin
            a1 = a1 + gap_pkg::DEG_360;
            a2 = a2 + gap_pkg::DEG_360;
         end
         if (a2 < 0) a2 = a2 + gap_pkg::DEG_360;
         if (a2 == '0) a2 = gap_pkg::DEG_360;
         if (side_d.cw) begin
            if (a1 <= a2) a2 = a2 - gap_pkg::DEG_360;
         end else begin
            if (a1 >= a2) a2 = a2 + gap_pkg::DEG_360;
         end
         bw = d1;
         bh = d1;
      end else begin
         case (side_d.q)
            gap_pkg::QUAD_1: begin
               a1 = al;
               a2 = be;
            end
            gap_pkg::QUAD_2: begin
               a1 = gap_pkg::DEG_180 - al;
               a2 = gap_pkg::DEG_180 - be;
            end
            gap_pkg::QUAD_3: begin
               a1 = gap_pkg::DEG_180 + al;
               a2 = gap_pkg::DEG_180 + be;
            end
            default: begin
               a1 = gap_pkg::DEG_360 - al;
               a2 = gap_pkg::DEG_360 - be;
            end
         endcase
         bw = (al < be) ? d1 : d2;
         bh = (al > be) ? d1 : d2;
         // both radii lie almost flat on the x axis
         if (f1 && f2) bh = '0;
      end
      r1 = (a1 + AW'(32)) >>> 6;
      r2 = (a2 + AW'(32)) >>> 6;
   end

   assign vld_in = {vld_ff[P-2:0], req_fire};
   assign rsp_valid_in = advance ? vld_ff[P-1] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) vld_ff <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_cx_ff <= side_d.cx;
         rsp_cy_ff <= side_d.cy;
         rsp_bw_ff <= bw;
         rsp_bh_ff <= bh;
         rsp_a1_ff <= r1[gap_pkg::ANGLE_BITS-1:0];
         rsp_a2_ff <= r2[gap_pkg::ANGLE_BITS-1:0];
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.center_x = rsp_cx_ff;
   assign rsp_ch.center_y = rsp_cy_ff;
   assign rsp_ch.box_width = rsp_bw_ff;
   assign rsp_ch.box_height = rsp_bh_ff;
   assign rsp_ch.start_angle = rsp_a1_ff;
   assign rsp_ch.end_angle = rsp_a2_ff;

endmodule

`default_nettype wire

// ===== design/gap_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gap_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_ready,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic [gap_pkg::ANGLE_BITS-1:0]       start_angle,
   input wire logic [gap_pkg::ANGLE_BITS-1:0]       end_angle
);

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // an empty output register never holds back a transfer
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   // a stalled result stops the pipeline
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("req taken while result stalled");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp valid dropped");

   a_angles_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(start_angle) && $stable(end_angle)))
      else $error("rsp angles changed while stalled");

endmodule

bind gerber_arc_parameters_top gap_checker u_gap_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .start_angle (rsp_ch.start_angle),
   .end_angle   (rsp_ch.end_angle)
);

`default_nettype wire

// ===== tb/gap_checker.sv =====
`timescale 1ns / 1ps

module gap_monitor (
   input  logic clock,
   input  logic reset,
   gap_req_if   req,
   gap_rsp_if   rsp,
   output int   errors,
   output int   pending
);

   localparam longint Q16_90 = 90 * 65536;
   localparam longint Q16_180 = 180 * 65536;
   localparam longint Q16_360 = 360 * 65536;
   localparam longint unsigned BOX_MAX = (64'd1 << 31) - 1;

   localparam longint ATAN_DEG_Q16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct {
      logic [28:0]                    center_x;
      logic [28:0]                    center_y;
      logic [30:0]                    box_width;
      logic [30:0]                    box_height;
      logic [gap_pkg::ANGLE_BITS-1:0] start_angle;
      logic [gap_pkg::ANGLE_BITS-1:0] end_angle;
   } arc_result_type;

   arc_result_type arc_results_q[$];

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   // first-quadrant vectoring, both components positive
   function automatic longint first_quad_angle(longint x, longint y);
      longint z, xs, ys;
      z = 0;
      x = x <<< gap_pkg::GUARD_SHIFT;
      y = y <<< gap_pkg::GUARD_SHIFT;
      for (int i = 0; i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += ATAN_DEG_Q16[i];
         end else begin
            x -= ys; y += xs; z -= ATAN_DEG_Q16[i];
         end
      end
      if (z < 1) z = 1;
      if (z > Q16_90 - 1) z = Q16_90 - 1;
      return z;
   endfunction

   function automatic longint vector_angle(longint x, longint y);
      longint t;
      if (y == 0) return x >= 0 ? 0 : Q16_180;
      if (x == 0) return y > 0 ? Q16_90 : -Q16_90;
      t = first_quad_angle(abs64(x), abs64(y));
      if (x > 0) return y > 0 ? t : -t;
      return y > 0 ? Q16_180 - t : t - Q16_180;
   endfunction

   function automatic logic [30:0] diameter(longint x, longint y);
      longint unsigned ax, ay, r, c, rem, d;
      logic [127:0] sq;
      ax = abs64(x);
      ay = abs64(y);
      sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
      r = 0;
      for (int b = 40; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (128'(c) * 128'(c) <= sq) r = c;
      end
      rem = sq[63:0] - r * r;
      d = 2 * r;
      if (16 * rem >= 24 * r + 9) d += 2;
      else if (16 * rem >= 8 * r + 1) d += 1;
      if (d > BOX_MAX) d = BOX_MAX;
      return d[30:0];
   endfunction

   function automatic logic [gap_pkg::ANGLE_BITS-1:0] out_angle(longint v);
      longint r;
      r = ((v + 1024 * 65536 + 32) >>> 6) - 1024 * 1024;
      return r[gap_pkg::ANGLE_BITS-1:0];
   endfunction

   function automatic arc_result_type predict_arc(longint sx, longint sy, longint ex,
                                                  longint ey, longint oi, longint oj,
                                                  logic cw, logic mq);
      arc_result_type res;
      longint cx, cy, a1, a2, d1x, d1y, d2x, d2y, al, be;
      int q;
      if (mq) begin
         cx = sx + oi;
         cy = sy + oj;
         a1 = vector_angle(sx - cx, sy - cy);
         a2 = vector_angle(ex - cx, ey - cy);
         res.box_width = diameter(oi, oj);
         res.box_height = res.box_width;
         if (a1 < 0) begin a1 += Q16_360; a2 += Q16_360; end
         if (a2 < 0) a2 += Q16_360;
         if (a2 == 0) a2 = Q16_360;
         if (cw) begin
            if (a1 <= a2) a2 -= Q16_360;
         end else begin
            if (a1 >= a2) a2 += Q16_360;
         end
      end else begin
         if (sx > ex) q = (sy < ey) ? 1 : 2;
         else q = (sy > ey) ? 3 : 4;
         if (cw) q = (q + 1) % 4 + 1;
         cx = (q == 1 || q == 4) ? sx - oi : sx + oi;
         cy = (q == 1 || q == 2) ? sy - oj : sy + oj;
         d1x = abs64(sx - cx); d1y = abs64(sy - cy);
         d2x = abs64(ex - cx); d2y = abs64(ey - cy);
         al = vector_angle(d1x, d1y);
         be = vector_angle(d2x, d2y);
         res.box_width = al < be ? diameter(d1x, d1y) : diameter(d2x, d2y);
         res.box_height = al > be ? diameter(d1x, d1y) : diameter(d2x, d2y);
         // nearly horizontal at both ends
         if (d1y * 1000000 <= d1x && d2y * 1000000 <= d2x) res.box_height = '0;
         case (q)
            1: begin a1 = al; a2 = be; end
            2: begin a1 = Q16_180 - al; a2 = Q16_180 - be; end
            3: begin a1 = Q16_180 + al; a2 = Q16_180 + be; end
            default: begin a1 = Q16_360 - al; a2 = Q16_360 - be; end
         endcase
      end
      res.center_x = cx[28:0];
      res.center_y = cy[28:0];
      res.start_angle = out_angle(a1);
      res.end_angle = out_angle(a2);
      return res;
   endfunction

   task automatic report(string field, longint unsigned want, longint unsigned got);
      errors++;
      if (errors <= 10)
         $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, field, want, got);
   endtask

   initial begin
      errors = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      arc_result_type want;
      if (!reset) begin
         if (req.valid && req.ready)
            arc_results_q.push_back(predict_arc(longint'(req.start_x), longint'(req.start_y),
               longint'(req.stop_x), longint'(req.stop_y), longint'(req.offset_i),
               longint'(req.offset_j), req.clockwise, req.multi_quadrant));
         if (rsp.valid && rsp.ready) begin
            if (arc_results_q.size() == 0) begin
               report("unexpected transfer", 0, 1);
            end else begin
               want = arc_results_q.pop_front();
               if (rsp.center_x !== want.center_x)
                  report("center_x", want.center_x, rsp.center_x);
               if (rsp.center_y !== want.center_y)
                  report("center_y", want.center_y, rsp.center_y);
               if (rsp.box_width !== want.box_width)
                  report("box_width", want.box_width, rsp.box_width);
               if (rsp.box_height !== want.box_height)
                  report("box_height", want.box_height, rsp.box_height);
               if (rsp.start_angle !== want.start_angle)
                  report("start_angle", want.start_angle, rsp.start_angle);
               if (rsp.end_angle !== want.end_angle)
                  report("end_angle", want.end_angle, rsp.end_angle);
            end
         end
         pending = arc_results_q.size();
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int CYCLE_LIMIT = 300000;
   localparam logic [27:0] C_MAX = 28'h7ffffff;
   localparam logic [27:0] C_MIN = 28'h8000000;

   typedef struct {
      logic [27:0] sx, sy, ex, ey, oi, oj;
      logic        cw, mq;
   } arc_type;

   logic clock;
   logic reset;
   logic rsp_hold;
   int   send_idle_pct;
   int   rsp_stall_pct;
   int   errors;
   int   pending;
   int   cycles;

   gap_req_if #(.COORD_BITS(28)) req_ch ();
   gap_rsp_if #(.COORD_BITS(28)) rsp_ch ();

   gerber_arc_parameters_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   gap_monitor u_checker (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .errors  (errors),
      .pending (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // receiver side
   always @(negedge clock) begin
      rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic logic [27:0] pick_coord();
      case ($urandom_range(5))
         0: return C_MAX;
         1: return C_MIN;
         2: return 28'(int'($urandom_range(2000)) - 1000);
         3: return 28'(int'($urandom_range(200000)) - 100000);
         default: return 28'($urandom());
      endcase
   endfunction

   function automatic arc_type random_arc();
      arc_type a;
      a.sx = pick_coord(); a.sy = pick_coord();
      a.ex = pick_coord(); a.ey = pick_coord();
      a.oi = pick_coord(); a.oj = pick_coord();
      a.cw = 1'($urandom_range(1));
      a.mq = 1'($urandom_range(1));
      // axis-aligned and degenerate radius vectors
      case ($urandom_range(7))
         0: a.oi = '0;
         1: a.oj = '0;
         2: begin a.oi = '0; a.oj = '0; end
         3: a.ey = a.sy;
         4: a.ex = a.sx;
         default: ;
      endcase
      return a;
   endfunction

   function automatic arc_type make_arc(logic [27:0] sx, logic [27:0] sy, logic [27:0] ex,
                                        logic [27:0] ey, logic [27:0] oi, logic [27:0] oj,
                                        logic cw, logic mq);
      arc_type a;
      a.sx = sx; a.sy = sy; a.ex = ex; a.ey = ey; a.oi = oi; a.oj = oj;
      a.cw = cw; a.mq = mq;
      return a;
   endfunction

   task automatic send_arc(arc_type a);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.start_x <= a.sx;
      req_ch.start_y <= a.sy;
      req_ch.stop_x <= a.ex;
      req_ch.stop_y <= a.ey;
      req_ch.offset_i <= a.oi;
      req_ch.offset_j <= a.oj;
      req_ch.clockwise <= a.cw;
      req_ch.multi_quadrant <= a.mq;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random(int count);
      repeat (count) send_arc(random_arc());
   endtask

   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      wait (pending == 0);
   endtask

   initial begin
      reset = 1'b1;
      rsp_hold = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      req_ch.valid = 1'b0;
      req_ch.start_x = '0;
      req_ch.start_y = '0;
      req_ch.stop_x = '0;
      req_ch.stop_y = '0;
      req_ch.offset_i = '0;
      req_ch.offset_j = '0;
      req_ch.clockwise = 1'b0;
      req_ch.multi_quadrant = 1'b0;
      rsp_ch.ready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, both modes and directions, axis and flat cases
      for (int m = 0; m < 2; m++) begin
         for (int d = 0; d < 2; d++) begin
            send_arc(make_arc('0, '0, '0, '0, '0, '0, 1'(d), 1'(m)));
            send_arc(make_arc(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, 1'(d), 1'(m)));
            send_arc(make_arc(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, 1'(d), 1'(m)));
            send_arc(make_arc(28'd100, '0, '0, 28'd100, -28'sd100, '0, 1'(d), 1'(m)));
            send_arc(make_arc(28'd10000000, 28'd1, -28'sd10000000, 28'd0,
                              -28'sd10000000, '0, 1'(d), 1'(m)));
         end
      end
      send_arc(make_arc('0, 28'd50, 28'd50, '0, '0, -28'sd50, 1'b1, 1'b0));
      send_arc(make_arc('0, -28'sd50, -28'sd50, '0, '0, 28'd50, 1'b0, 1'b0));
      send_arc(make_arc(28'd5, 28'd5, 28'd5, 28'd5, 28'd3, 28'd4, 1'b0, 1'b1));
      send_arc(make_arc(28'd5, 28'd5, 28'd5, 28'd5, 28'd3, 28'd4, 1'b1, 1'b1));
      send_arc(make_arc(-28'sd7, 28'd9, 28'd2, -28'sd3, 28'd0, 28'd6, 1'b1, 1'b0));
      drain();

      send_random(150);
      send_idle_pct = 77;
      send_random(150);
      send_idle_pct = 0;
      rsp_stall_pct = 77;
      send_random(150);
      send_idle_pct = 25;
      rsp_stall_pct = 25;
      send_random(150);
      // sender pauses until everything is back
      drain();

      // long receiver hold-off while items keep coming
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fork
         begin
            @(negedge clock);
            rsp_hold <= 1'b1;
            repeat (300) @(negedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      send_random(100);
      drain();

      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/gap_pkg.sv
design/gap_if.sv
design/gap_delay.sv
design/gap_cordic_cell.sv
design/gap_angle.sv
design/gap_sqrt_cell.sv
design/gap_diam.sv
design/gerber_arc_parameters_top.sv
design/gap_checker.sv
tb/gap_checker.sv
tb/testbench.sv
